// ===== src/frs_pkg.sv =====
`default_nettype none

package frs_pkg;

    // Tree geometry
    localparam int MAX_POSITIONS = 1024;
    localparam int ADDR_W        = $clog2(MAX_POSITIONS);
    localparam int POS_W         = 11;
    localparam int WALK_W        = POS_W + 1;
    localparam int DATA_W        = 64;
    localparam int OP_W          = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PLAIN_ADD = 2'd0;
    localparam logic [OP_W-1:0] OP_PROG_ADD  = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY     = 2'd2;

    // Node memory port: one write and one read address per cycle
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    // One accepted word handed to the walker
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] amt;
        logic [POS_W-1:0]  lo;
        logic [POS_W-1:0]  hi;
    } t_walk_req;

    // Walker status toward the top level
    typedef struct packed {
        logic              idle;
        logic              done;
        logic [DATA_W-1:0] sum;
    } t_walk_status;

endpackage

`default_nettype wire

// ===== src/frs_node_ram.sv =====
`default_nettype none

module frs_node_ram (
    input  wire logic                     i_clk,
    input  wire frs_pkg::t_mem_req        i_req,
    output logic [frs_pkg::DATA_W-1:0]    o_rdata
);
    import frs_pkg::*;

    logic [DATA_W-1:0] r_mem [MAX_POSITIONS];
    logic [DATA_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/frs_walker.sv =====
`default_nettype none

module frs_walker (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [frs_pkg::POS_W-1:0] i_size,
    input  wire logic                      i_start,
    input  wire frs_pkg::t_walk_req        i_req,
    input  wire logic                      i_take,
    input  wire logic [frs_pkg::DATA_W-1:0] i_rdata,
    output frs_pkg::t_mem_req              o_mem,
    output frs_pkg::t_walk_status          o_status
);
    import frs_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_UPD   = 3'd2;
    localparam logic [2:0] ST_QRY   = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_HOLD  = 3'd5;

    localparam logic [WALK_W-1:0] MAX_WALK = WALK_W'(MAX_POSITIONS);

    logic [2:0]        r_state,      n_state;
    logic [ADDR_W-1:0] r_clr_cnt,    n_clr_cnt;
    logic [WALK_W-1:0] r_pos,        n_pos;
    logic [WALK_W-1:0] r_limit,      n_limit;
    logic [DATA_W-1:0] r_delta,      n_delta;
    logic [DATA_W-1:0] r_amt,        n_amt;
    logic              r_prog,       n_prog;
    logic              r_is_qry,     n_is_qry;
    logic              r_phase,      n_phase;
    logic [POS_W-1:0]  r_lo,         n_lo;
    logic [DATA_W-1:0] r_acc,        n_acc;
    logic              r_pend,       n_pend;
    logic              r_pend_sub,   n_pend_sub;
    logic [ADDR_W-1:0] r_pend_addr,  n_pend_addr;
    logic [DATA_W-1:0] r_pend_delta, n_pend_delta;

    logic [WALK_W-1:0] pos_low;
    logic [WALK_W-1:0] pos_m1;
    logic [WALK_W-1:0] size_ext;

    assign pos_low  = r_pos & (~r_pos + WALK_W'(1));
    assign pos_m1   = r_pos - WALK_W'(1);
    assign size_ext = {1'b0, i_size};

    // Sequence the walks and the clearing pass
    always_comb begin
        n_state      = r_state;
        n_clr_cnt    = r_clr_cnt;
        n_pos        = r_pos;
        n_limit      = r_limit;
        n_delta      = r_delta;
        n_amt        = r_amt;
        n_prog       = r_prog;
        n_is_qry     = r_is_qry;
        n_phase      = r_phase;
        n_lo         = r_lo;
        n_acc        = r_acc;
        n_pend       = 1'b0;
        n_pend_sub   = r_pend_sub;
        n_pend_addr  = r_pend_addr;
        n_pend_delta = r_pend_delta;
        o_mem        = '0;

        // Retire the read issued last cycle: accumulate or write back
        if (r_pend) begin
            if (r_is_qry) begin
                n_acc = r_pend_sub ? (r_acc - i_rdata) : (r_acc + i_rdata);
            end else begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_pend_addr;
                o_mem.wdata = i_rdata + r_pend_delta;
            end
        end

        unique case (r_state)
            ST_CLEAR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_clr_cnt;
                o_mem.wdata = '0;
                n_clr_cnt   = r_clr_cnt + ADDR_W'(1);
                if (r_clr_cnt == ADDR_W'(MAX_POSITIONS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    unique case (i_req.op) inside
                        OP_PLAIN_ADD, OP_PROG_ADD: begin
                            if (i_req.pos != '0) begin
                                n_state  = ST_UPD;
                                n_pos    = {1'b0, i_req.pos};
                                n_delta  = i_req.amt;
                                n_amt    = i_req.amt;
                                n_prog   = (i_req.op == OP_PROG_ADD);
                                n_is_qry = 1'b0;
                                n_limit  = (size_ext > MAX_WALK) ? MAX_WALK : size_ext;
                            end
                        end
                        OP_QUERY: begin
                            n_state  = ST_QRY;
                            n_pos    = {1'b0, i_req.hi};
                            n_lo     = i_req.lo;
                            n_phase  = 1'b0;
                            n_is_qry = 1'b1;
                            n_acc    = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_UPD: begin
                // Issue one node read per cycle up the lowbit path
                if (r_pos <= r_limit) begin
                    o_mem.re     = 1'b1;
                    o_mem.raddr  = pos_m1[ADDR_W-1:0];
                    n_pend       = 1'b1;
                    n_pend_addr  = pos_m1[ADDR_W-1:0];
                    n_pend_delta = r_delta;
                    if (r_prog) begin
                        n_delta = r_delta + r_amt;
                    end
                    n_pos = r_pos + pos_low;
                end else begin
                    n_state = ST_DRAIN;
                end
            end
            ST_QRY: begin
                // Walk down by lowbit; nodes past the memory count as zero
                if (r_pos != '0) begin
                    if (r_pos <= MAX_WALK) begin
                        o_mem.re    = 1'b1;
                        o_mem.raddr = pos_m1[ADDR_W-1:0];
                        n_pend      = 1'b1;
                        n_pend_sub  = r_phase;
                    end
                    n_pos = r_pos - pos_low;
                end else if (!r_phase && (r_lo != '0)) begin
                    n_phase = 1'b1;
                    n_pos   = {1'b0, r_lo - POS_W'(1)};
                end else begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = r_is_qry ? ST_HOLD : ST_IDLE;
            end
            ST_HOLD: begin
                if (i_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_cnt <= '0;
            r_pend    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= n_clr_cnt;
            r_pend    <= n_pend;
        end
    end

    // Walk payload
    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_limit      <= n_limit;
        r_delta      <= n_delta;
        r_amt        <= n_amt;
        r_prog       <= n_prog;
        r_is_qry     <= n_is_qry;
        r_phase      <= n_phase;
        r_lo         <= n_lo;
        r_acc        <= n_acc;
        r_pend_sub   <= n_pend_sub;
        r_pend_addr  <= n_pend_addr;
        r_pend_delta <= n_pend_delta;
    end

    assign o_status.idle = (r_state == ST_IDLE);
    assign o_status.done = (r_state == ST_HOLD);
    assign o_status.sum  = r_acc;

    // Checks
    a_no_rw_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem.we && o_mem.re) |-> (o_mem.waddr != o_mem.raddr))
        else $error("read and write hit the same node in one cycle");

    a_clear_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_mem.re)
        else $error("node read during clearing pass");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == ST_IDLE))
        else $error("word started while walker busy");

    a_pend_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> ((r_state == ST_UPD) || (r_state == ST_QRY) || (r_state == ST_DRAIN)))
        else $error("pending node read outside a walk");

    a_take_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take |-> (r_state == ST_HOLD))
        else $error("result taken without a finished query");

endmodule

`default_nettype wire

// ===== src/fenwick_range_sum_engine_top.sv =====
// Channel   Direction  Handshake                   Word
// input     in         i_in_valid / o_in_stall     op, update_position, amount, bounds
// output    out        o_out_valid / i_out_stall   range_sum
// config    in         i_cfg_we                    size_in_use (11 bits)
//
// An update visits N nodes on its upward path within the size (at most 11). A query walks
// the P steps of both downward prefix paths (at most 21), skipping the second path with a
// left bound of zero; one node read per cycle through the node memory's read port.
// After reset a clearing pass zeroes all 1024 nodes; input is stalled then.
// A finished query waits in the walker until the output register is free.
`default_nettype none

module fenwick_range_sum_engine_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [frs_pkg::OP_W-1:0]          i_op,
    input  wire logic [frs_pkg::POS_W-1:0]         i_update_position,
    input  wire logic signed [frs_pkg::DATA_W-1:0] i_amount,
    input  wire logic [frs_pkg::POS_W-1:0]         i_left_bound,
    input  wire logic [frs_pkg::POS_W-1:0]         i_right_bound,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic signed [frs_pkg::DATA_W-1:0]      o_range_sum,
    input  wire logic                              i_cfg_we,
    input  wire logic [frs_pkg::POS_W-1:0]         i_cfg_wdata
);
    import frs_pkg::*;

    logic [POS_W-1:0]  r_size;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_sum;

    t_walk_req         walk_req;
    t_walk_status      walk_status;
    t_mem_req          mem_req;
    logic [DATA_W-1:0] mem_rdata;
    logic              in_accept;
    logic              take;

    // Accept a word only while the walker is idle
    assign o_in_stall = !walk_status.idle;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign walk_req.op  = i_op;
    assign walk_req.pos = i_update_position;
    assign walk_req.amt = i_amount;
    assign walk_req.lo  = i_left_bound;
    assign walk_req.hi  = i_right_bound;

    // Size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= POS_W'(MAX_POSITIONS);
        end else if (i_cfg_we) begin
            r_size <= i_cfg_wdata;
        end
    end

    // Output register: load when empty or being drained
    assign take = walk_status.done && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_sum <= walk_status.sum;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_range_sum = r_out_sum;

    frs_walker u_walker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_size   (r_size),
        .i_start  (in_accept),
        .i_req    (walk_req),
        .i_take   (take),
        .i_rdata  (mem_rdata),
        .o_mem    (mem_req),
        .o_status (walk_status)
    );

    frs_node_ram u_node_ram (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

endmodule

`default_nettype wire

// ===== verif/fenwick_range_sum_engine_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fenwick_range_sum_engine_checker (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire logic                       i_in_stall,
    input  wire logic [frs_pkg::OP_W-1:0]   i_op,
    input  wire logic [frs_pkg::POS_W-1:0]  i_update_position,
    input  wire logic [frs_pkg::DATA_W-1:0] i_amount,
    input  wire logic [frs_pkg::POS_W-1:0]  i_left_bound,
    input  wire logic [frs_pkg::POS_W-1:0]  i_right_bound,
    input  wire logic                       i_out_valid,
    input  wire logic                       i_out_stall,
    input  wire logic [frs_pkg::DATA_W-1:0] i_range_sum,
    input  wire logic                       i_cfg_we,
    input  wire logic [frs_pkg::POS_W-1:0]  i_cfg_wdata,
    output int                              o_fail_count,
    output int                              o_sums_pending,
    output int                              o_sums_checked
);

    import frs_pkg::*;

    // Shadow copy of the tree and the size register
    logic [DATA_W-1:0] tree_shadow [1:MAX_POSITIONS];
    logic [POS_W-1:0]  size_shadow;
    logic [DATA_W-1:0] sum_queue [$];
    logic [DATA_W-1:0] sum_expected;

    // Walk upward by lowbit and add; a progressive add grows the step at each node
    task automatic add_along_path(input int start, input logic [DATA_W-1:0] amt,
                                  input bit progressive);
        int                node;
        int                bound;
        logic [DATA_W-1:0] delta;
        node  = start;
        bound = (size_shadow > MAX_POSITIONS) ? MAX_POSITIONS : int'(size_shadow);
        delta = amt;
        if (node == 0)
            return;
        while (node <= bound) begin
            tree_shadow[node] = tree_shadow[node] + delta;
            if (progressive)
                delta = delta + amt;
            node = node + (node & -node);
        end
    endtask

    // Walk downward by lowbit; nodes past the memory read as zero
    function automatic logic [DATA_W-1:0] prefix_total(input int upto);
        int                node;
        logic [DATA_W-1:0] acc;
        node = upto;
        acc  = '0;
        while (node > 0) begin
            if (node <= MAX_POSITIONS)
                acc = acc + tree_shadow[node];
            node = node - (node & -node);
        end
        return acc;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 1; n <= MAX_POSITIONS; n++)
                tree_shadow[n] = '0;
            size_shadow = POS_W'(MAX_POSITIONS);
            sum_queue.delete();
            o_fail_count   = 0;
            o_sums_checked = 0;
        end else begin
            // Compare a delivered sum with the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (sum_queue.size() == 0) begin
                    $error("range_sum: no word expected, got %0d", $signed(i_range_sum));
                    o_fail_count++;
                end else begin
                    sum_expected = sum_queue.pop_front();
                    o_sums_checked++;
                    if (i_range_sum !== sum_expected) begin
                        $error("range_sum mismatch: expected %0d, got %0d",
                               $signed(sum_expected), $signed(i_range_sum));
                        o_fail_count++;
                    end
                end
            end

            // Advance the shadow tree on an accepted add, or queue a prediction on an accepted query
            if (i_in_valid && !i_in_stall) begin
                case (i_op)
                    OP_PLAIN_ADD: add_along_path(int'(i_update_position), i_amount, 1'b0);
                    OP_PROG_ADD:  add_along_path(int'(i_update_position), i_amount, 1'b1);
                    OP_QUERY: begin
                        sum_queue.push_back(prefix_total(int'(i_right_bound)) -
                            ((i_left_bound == '0) ? '0 :
                             prefix_total(int'(i_left_bound) - 1)));
                    end
                    default: ;
                endcase
            end

            if (i_cfg_we)
                size_shadow = i_cfg_wdata;
        end
        o_sums_pending = sum_queue.size();
    end

endmodule

`default_nettype wire

// ===== verif/fenwick_range_sum_engine_top_test.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fenwick_range_sum_engine_top_test;

    import frs_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED     = 2'd3;
    localparam int              SETTLE_CYCLES = 40;
    localparam int              PHASE_WORDS   = 150;

    logic                     clk          = 1'b0;
    logic                     rst_n        = 1'b0;
    logic                     in_valid     = 1'b0;
    logic                     in_stall;
    logic [OP_W-1:0]          op           = OP_PLAIN_ADD;
    logic [POS_W-1:0]         update_pos   = '0;
    logic signed [DATA_W-1:0] amount       = '0;
    logic [POS_W-1:0]         left_bound   = '0;
    logic [POS_W-1:0]         right_bound  = '0;
    logic                     out_valid;
    logic                     out_stall    = 1'b0;
    logic signed [DATA_W-1:0] range_sum;
    logic                     cfg_we       = 1'b0;
    logic [POS_W-1:0]         cfg_wdata    = '0;

    int fail_count;
    int sums_pending;
    int sums_checked;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int words_sent     = 0;
    int sizes_set      = 0;
    int size_now       = MAX_POSITIONS;

    int phase_size [6] = '{1, 1024, 2, 2047, 17, 0};

    always #5 clk = ~clk;

    fenwick_range_sum_engine_top u_top (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_op              (op),
        .i_update_position (update_pos),
        .i_amount          (amount),
        .i_left_bound      (left_bound),
        .i_right_bound     (right_bound),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_range_sum       (range_sum),
        .i_cfg_we          (cfg_we),
        .i_cfg_wdata       (cfg_wdata)
    );

    fenwick_range_sum_engine_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_op              (op),
        .i_update_position (update_pos),
        .i_amount          (amount),
        .i_left_bound      (left_bound),
        .i_right_bound     (right_bound),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_range_sum       (range_sum),
        .i_cfg_we          (cfg_we),
        .i_cfg_wdata       (cfg_wdata),
        .o_fail_count      (fail_count),
        .o_sums_pending    (sums_pending),
        .o_sums_checked    (sums_checked)
    );

    // Stall the result channel at random
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // Offer one word, idling first at random, and hold it until accepted
    task automatic send_word(input logic [OP_W-1:0] w_op, input int w_pos,
                             input logic [DATA_W-1:0] w_amt, input int w_lo, input int w_hi);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= w_op;
        update_pos  <= POS_W'(w_pos);
        amount      <= w_amt;
        left_bound  <= POS_W'(w_lo);
        right_bound <= POS_W'(w_hi);
        do @(posedge clk); while (in_stall);
        words_sent++;
    endtask

    // Drop valid and wait for every predicted sum plus the walk latency
    task automatic settle();
        in_valid <= 1'b0;
        do @(negedge clk); while (sums_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_size(input int value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= POS_W'(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
        size_now  = (value > MAX_POSITIONS) ? MAX_POSITIONS : value;
        sizes_set++;
    endtask

    function automatic logic [DATA_W-1:0] pick_amount();
        case ($urandom_range(9))
            0:       return {1'b1, {(DATA_W-1){1'b0}}};
            1:       return {1'b0, {(DATA_W-1){1'b1}}};
            2:       return '1;
            3, 4, 5: return DATA_W'(longint'($urandom_range(200)) - 100);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Adds, mostly inside the size, and queries over random ranges, some noise
    task automatic random_word();
        int                kind;
        int                pos;
        int                lo;
        int                hi;
        int                tmp;
        logic [OP_W-1:0]   w_op;
        kind = $urandom_range(99);
        pos  = $urandom_range(MAX_POSITIONS);
        lo   = $urandom_range(1, MAX_POSITIONS);
        hi   = $urandom_range(lo, MAX_POSITIONS);
        if (kind < 25)
            w_op = OP_PLAIN_ADD;
        else if (kind < 45)
            w_op = OP_PROG_ADD;
        else if (kind < 96)
            w_op = OP_QUERY;
        else
            w_op = OP_UNUSED;
        if (w_op != OP_QUERY && $urandom_range(9) > 0)
            pos = (size_now == 0) ? $urandom_range(1, MAX_POSITIONS)
                                  : $urandom_range(1, size_now);
        case ($urandom_range(9))
            0: lo = 0;
            1: begin
                tmp = lo;
                lo  = hi;
                hi  = tmp;
            end
            2: hi = 0;
            3: hi = MAX_POSITIONS;
            default: ;
        endcase
        send_word(w_op, pos, pick_amount(), lo, hi);
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words at the reset size
        send_word(OP_PLAIN_ADD, 1, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0);
        send_word(OP_PLAIN_ADD, 1024, 64'h8000_0000_0000_0000, 0, 0);
        send_word(OP_PROG_ADD, 3, '1, 0, 0);
        send_word(OP_PROG_ADD, 1, 64'h5555_5555_5555_5555, 0, 0);
        send_word(OP_PLAIN_ADD, 0, 64'd123, 0, 0);
        send_word(OP_PLAIN_ADD, 2047, 64'd99, 0, 0);
        send_word(OP_UNUSED, 5, 64'd77, 1, 1024);
        send_word(OP_QUERY, 0, '0, 1, 1024);
        send_word(OP_QUERY, 0, '0, 0, 1024);
        send_word(OP_QUERY, 0, '0, 1024, 1024);
        send_word(OP_QUERY, 0, '0, 5, 2);
        send_word(OP_QUERY, 0, '0, 1, 0);
        send_word(OP_QUERY, 0, '0, 1, 2047);
        send_word(OP_QUERY, 0, '0, 2047, 2047);
        send_word(OP_PLAIN_ADD, 513, '1, 0, 0);
        send_word(OP_PROG_ADD, 1023, 64'hAAAA_AAAA_AAAA_AAAA, 0, 0);
        send_word(OP_QUERY, 0, '0, 512, 1023);
        send_word(OP_QUERY, 0, '0, 0, 0);

        // A zero size blocks every update; an oversized one is capped
        write_size(0);
        send_word(OP_PLAIN_ADD, 1, 64'd1000, 0, 0);
        send_word(OP_PROG_ADD, 2, 64'd5, 0, 0);
        send_word(OP_QUERY, 0, '0, 1, 1024);
        write_size(2047);
        send_word(OP_PROG_ADD, 1000, 64'd3, 0, 0);
        send_word(OP_QUERY, 0, '0, 1, 1024);

        // Random phases, one size each; idling swaps sides, then stops
        phase_size[5] = $urandom_range(3, 1023);
        for (int ph = 0; ph < 6; ph++) begin
            write_size(phase_size[ph]);
            send_idle_pct  = (ph < 2) ? 24 : (ph < 4) ? 48 : 0;
            recv_stall_pct = (ph < 2) ? 48 : (ph < 4) ? 24 : 0;
            for (int k = 0; k < PHASE_WORDS; k++) begin
                if (ph == 1 && k == PHASE_WORDS / 2)
                    settle();
                random_word();
            end
        end

        in_valid <= 1'b0;
        do @(negedge clk); while (sums_pending != 0);
        repeat (50) @(posedge clk);

        $display("Covered %0d input words and %0d checked range sums over %0d size settings,",
                 words_sent, sums_checked, sizes_set + 1);
        $display("including zero and capped sizes and stalls on both channels.");
        if (fail_count == 0 && sums_pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Hold a hard stop well past the slowest correct run
    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
